[rtl/skt_pkg.sv]
`timescale 1ns / 1ps

package skt_pkg;

	// Fixed field widths of the request and result ports
	localparam int CMD_W      = 2;
	localparam int IN_KEY_W   = 16;
	localparam int STATUS_W   = 2;
	localparam int ECOUNT_W   = 9;

	// Cells per first-level match group
	localparam int GROUP_W    = 16;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_MEMBER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS_OR_DUP = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL        = 2'd2;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_UPD
	} state_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
	} cell_ctrl_t;

endpackage

[rtl/skt_cell.sv]
`timescale 1ns / 1ps

module skt_cell #(
	parameter int KEY_WIDTH = 16,
	parameter int CNT_W     = 9,
	parameter int INDEX     = 0
) (
	input  logic                  clk,
	input  skt_pkg::cell_ctrl_t   ctrl,
	input  logic [KEY_WIDTH-1:0]  req_key,
	input  logic [CNT_W-1:0]      count,
	input  logic [KEY_WIDTH-1:0]  left_key,
	input  logic                  left_lt,
	input  logic [KEY_WIDTH-1:0]  right_key,
	output logic [KEY_WIDTH-1:0]  key_out,
	output logic                  lt_out,
	output logic                  eq_out
);
	import skt_pkg::*;

	logic [KEY_WIDTH-1:0] key_q;
	logic                 lt_q;
	logic                 occupied;

	// Compare the held key against the request key
	assign occupied = CNT_W'(INDEX) < count;
	assign eq_out   = occupied && (key_q == req_key);
	assign key_out  = key_q;
	assign lt_out   = lt_q;

	// Latch the below-key flag for the update cycle
	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			lt_q <= occupied && (key_q < req_key);
		end
	end

	// Shift right on insert, shift left on delete, at and above the slot
	always_ff @(posedge clk) begin
		if (ctrl.ins && !lt_q) begin
			if (left_lt) begin
				key_q <= req_key;
			end else begin
				key_q <= left_key;
			end
		end else if (ctrl.del && !lt_q) begin
			key_q <= right_key;
		end
	end

endmodule

[rtl/sorted_key_set_table.sv]
// A request runs capture, a parallel compare in all cells with a grouped match reduction, then a shift;
// the shift and the result register load wait while a stalled result still sits at the output.
// No new request is taken until the previous one has finished its shift.
// A new request is taken while the previous result still waits at the output.
// Reset clears the entry count and the control state; the cells are not
// cleared, so there is no clearing pass and the block is ready at once.
`timescale 1ns / 1ps

module sorted_key_set_table #(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [skt_pkg::CMD_W-1:0]     cmd,
	input  logic [skt_pkg::IN_KEY_W-1:0]  key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [skt_pkg::STATUS_W-1:0]  status,
	output logic [skt_pkg::ECOUNT_W-1:0]  entry_count
);
	import skt_pkg::*;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int NGROUP = (CAPACITY + GROUP_W - 1) / GROUP_W;

	state_t state_q, state_d;
	cell_ctrl_t ctrl;

	logic [CMD_W-1:0]      cmd_q;
	logic [KEY_WIDTH-1:0]  key_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic [NGROUP-1:0]     grp_q;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [ECOUNT_W-1:0]   ecount_q;

	logic [KEY_WIDTH-1:0]       cell_key [CAPACITY];
	logic [CAPACITY-1:0]        cell_lt;
	logic [NGROUP*GROUP_W-1:0]  eq_pad;

	logic                       accept;
	logic                       advance;
	logic                       held;
	logic                       full;
	logic                       ins_en;
	logic                       del_en;
	logic [STATUS_W-1:0]        status_d;
	logic [KEY_WIDTH+IN_KEY_W-1:0] key_wide;
	logic [CNT_W+ECOUNT_W-1:0]     count_wide;

	assign key_wide   = (KEY_WIDTH + IN_KEY_W)'(key);
	assign accept     = in_valid && !in_stall;
	assign advance    = !out_valid_q || !out_stall;
	assign held       = |grp_q;
	assign full       = count_q == CNT_W'(CAPACITY);
	assign count_wide = (CNT_W + ECOUNT_W)'(count_d);

	// Build the chain of cells
	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic [KEY_WIDTH-1:0] left_key;
			logic [KEY_WIDTH-1:0] right_key;
			logic                 left_lt;
			if (i == 0) begin : g_first
				assign left_key = '0;
				assign left_lt  = 1'b1;
			end else begin : g_mid
				assign left_key = cell_key[i-1];
				assign left_lt  = cell_lt[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign right_key = '0;
			end else begin : g_inner
				assign right_key = cell_key[i+1];
			end
			skt_cell #(
				.KEY_WIDTH (KEY_WIDTH),
				.CNT_W     (CNT_W),
				.INDEX     (i)
			) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.req_key   (key_q),
				.count     (count_q),
				.left_key  (left_key),
				.left_lt   (left_lt),
				.right_key (right_key),
				.key_out   (cell_key[i]),
				.lt_out    (cell_lt[i]),
				.eq_out    (eq_pad[i])
			);
		end
		if (NGROUP * GROUP_W > CAPACITY) begin : g_pad
			assign eq_pad[NGROUP*GROUP_W-1:CAPACITY] = '0;
		end
	endgenerate

	// Reduce match flags per group during the compare cycle
	generate
		for (genvar g = 0; g < NGROUP; g++) begin : g_grp
			always_ff @(posedge clk) begin
				if (ctrl.cmp) begin
					grp_q[g] <= |eq_pad[g*GROUP_W +: GROUP_W];
				end
			end
		end
	endgenerate

	// Capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			key_q <= key_wide[KEY_WIDTH-1:0];
		end
	end

	// Decide status and table change
	always_comb begin
		ins_en   = 1'b0;
		del_en   = 1'b0;
		status_d = held ? ST_OK : ST_MISS_OR_DUP;
		case (cmd_q)
			CMD_INSERT: begin
				if (held) begin
					status_d = ST_MISS_OR_DUP;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_OK;
					ins_en   = 1'b1;
				end
			end
			CMD_DELETE: begin
				del_en = held;
			end
			default: begin
			end
		endcase
		count_d = count_q;
		if (ins_en) begin
			count_d = count_q + CNT_W'(1);
		end else if (del_en) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the sequencer and drive cell control
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		ctrl     = '0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				ctrl.cmp = 1'b1;
				state_d  = S_UPD;
			end
			S_UPD: begin
				if (advance) begin
					ctrl.ins = ins_en;
					ctrl.del = del_en;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Update the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == S_UPD && advance) begin
			count_q <= count_d;
		end
	end

	// Load or drop the output transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_UPD && advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPD && advance) begin
			status_q <= status_d;
			ecount_q <= count_wide[ECOUNT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = ecount_q;

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && advance && ins_en) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the count");

	a_rose_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_UPD))
		else $error("result without update cycle");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_FULL) |-> (count_q == CNT_W'(CAPACITY)))
		else $error("full status with room left");

	a_one_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.ins && ctrl.del))
		else $error("insert and delete shift together");
`endif

endmodule

[tb/sv/sorted_key_set_table_test.sv]
`timescale 1ns / 1ps

module sorted_key_set_table_test;

	import skt_pkg::*;

	localparam int CAPACITY     = 256;
	localparam int HOLD_CYCLES  = 80;
	localparam int TAIL_CYCLES  = 20;
	localparam int QUIET_LIMIT  = 4000;

	// Spare command code: the block treats it as a membership query
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ECOUNT_W-1:0] entry_count;
	} result_t;

	typedef struct packed {
		logic [CMD_W-1:0]    op;
		logic [IN_KEY_W-1:0] k;
		logic                typed;
		logic [STATUS_W-1:0] st;
		logic [ECOUNT_W-1:0] cnt;
	} script_row_t;

	localparam int SCRIPT_LEN = 22;

	// Directed opening: typed results only where they are obvious
	script_row_t script [SCRIPT_LEN] = '{
		'{CMD_MEMBER, 16'h0000, 1'b1, ST_MISS_OR_DUP, 9'd0}, // query right after reset
		'{CMD_DELETE, 16'h0000, 1'b1, ST_MISS_OR_DUP, 9'd0}, // delete from an empty table
		'{CMD_INSERT, 16'hFFFF, 1'b1, ST_OK,          9'd1},
		'{CMD_INSERT, 16'h0000, 1'b1, ST_OK,          9'd2},
		'{CMD_INSERT, 16'hFFFF, 1'b1, ST_MISS_OR_DUP, 9'd2}, // duplicate insert
		'{CMD_MEMBER, 16'hFFFF, 1'b1, ST_OK,          9'd2},
		'{CMD_SPARE,  16'h0000, 1'b1, ST_OK,          9'd2}, // spare code, key held
		'{CMD_SPARE,  16'h1234, 1'b1, ST_MISS_OR_DUP, 9'd2}, // spare code, key absent
		'{CMD_INSERT, 16'h8000, 1'b0, ST_OK,          9'd0},
		'{CMD_INSERT, 16'h7FFF, 1'b0, ST_OK,          9'd0},
		'{CMD_INSERT, 16'h8001, 1'b0, ST_OK,          9'd0},
		'{CMD_MEMBER, 16'h8000, 1'b0, ST_OK,          9'd0},
		'{CMD_DELETE, 16'h8000, 1'b0, ST_OK,          9'd0},
		'{CMD_MEMBER, 16'h8000, 1'b0, ST_OK,          9'd0},
		'{CMD_DELETE, 16'h0000, 1'b0, ST_OK,          9'd0},
		'{CMD_DELETE, 16'hFFFF, 1'b0, ST_OK,          9'd0},
		'{CMD_DELETE, 16'h1234, 1'b0, ST_OK,          9'd0},
		'{CMD_INSERT, 16'h5555, 1'b0, ST_OK,          9'd0},
		'{CMD_INSERT, 16'hAAAA, 1'b0, ST_OK,          9'd0},
		'{CMD_MEMBER, 16'hAAAA, 1'b0, ST_OK,          9'd0},
		'{CMD_DELETE, 16'h7FFF, 1'b0, ST_OK,          9'd0},
		'{CMD_MEMBER, 16'h5555, 1'b0, ST_OK,          9'd0}
	};

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic [CMD_W-1:0]    cmd         = CMD_MEMBER;
	logic [IN_KEY_W-1:0] key         = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [ECOUNT_W-1:0] entry_count;

	// Mirror of the table contents
	logic [IN_KEY_W-1:0] held_keys [CAPACITY];
	int                  held_count = 0;

	result_t expected_results [$];
	int      fail_count    = 0;
	int      quiet_cycles  = 0;
	int      send_idle_pct = 0;
	int      stall_pct     = 0;
	bit      hold_req      = 1'b0;

	sorted_key_set_table #(
		.CAPACITY(CAPACITY),
		.KEY_WIDTH(IN_KEY_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.key(key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.entry_count(entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the mirror and return the result it produces
	function automatic result_t apply_request(logic [CMD_W-1:0] op, logic [IN_KEY_W-1:0] k);
		int      pos;
		bit      held;
		result_t r;
		pos = 0;
		while (pos < held_count && held_keys[pos] < k)
			pos++;
		held = (pos < held_count) && (held_keys[pos] == k);
		case (op)
			CMD_INSERT: begin
				if (held) begin
					r.status = ST_MISS_OR_DUP;
				end else if (held_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (int i = held_count; i > pos; i--)
						held_keys[i] = held_keys[i-1];
					held_keys[pos] = k;
					held_count++;
					r.status = ST_OK;
				end
			end
			CMD_DELETE: begin
				if (held) begin
					for (int i = pos; i < held_count - 1; i++)
						held_keys[i] = held_keys[i+1];
					held_count--;
					r.status = ST_OK;
				end else begin
					r.status = ST_MISS_OR_DUP;
				end
			end
			default: begin
				r.status = held ? ST_OK : ST_MISS_OR_DUP;
			end
		endcase
		r.entry_count = ECOUNT_W'(held_count);
		return r;
	endfunction

	// Favor keys that are held or sit next to held keys, so hits are common
	function automatic logic [IN_KEY_W-1:0] pick_key();
		int unsigned         sel;
		logic [IN_KEY_W-1:0] k;
		sel = $urandom_range(99);
		if (held_count != 0 && sel < 45) begin
			k = held_keys[$urandom_range(held_count - 1)];
		end else if (held_count != 0 && sel < 60) begin
			k = held_keys[$urandom_range(held_count - 1)];
			k = $urandom_range(1) ? k + 1'b1 : k - 1'b1;
		end else if (sel < 70) begin
			case ($urandom_range(3))
				0: k = 16'h0000;
				1: k = 16'hFFFF;
				2: k = 16'h8000;
				default: k = 16'h7FFF;
			endcase
		end else begin
			k = IN_KEY_W'($urandom);
		end
		return k;
	endfunction

	function automatic logic [CMD_W-1:0] pick_cmd(int ins_pct, int del_pct);
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < ins_pct)
			return CMD_INSERT;
		else if (sel < ins_pct + del_pct)
			return CMD_DELETE;
		else if (sel < 95)
			return CMD_MEMBER;
		return CMD_SPARE;
	endfunction

	// Offer one transaction, wait for it to be taken, then record its result
	task automatic send_request(input logic [CMD_W-1:0] op, input logic [IN_KEY_W-1:0] k,
			input logic typed = 1'b0, input logic [STATUS_W-1:0] st = ST_OK,
			input logic [ECOUNT_W-1:0] cnt = '0);
		result_t predicted;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		key      <= k;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = apply_request(op, k);
		if (typed) begin
			predicted.status      = st;
			predicted.entry_count = cnt;
		end
		expected_results.push_back(predicted);
	endtask

	task automatic send_random(input int n, input int ins_pct, input int del_pct);
		for (int i = 0; i < n; i++)
			send_request(pick_cmd(ins_pct, del_pct), pick_key());
	endtask

	// Drop valid and hold off until every result is back
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_result
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d entry_count %0d", status, entry_count);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						want.entry_count, entry_count);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, no idling
		foreach (script[i])
			send_request(script[i].op, script[i].k, script[i].typed, script[i].st,
				script[i].cnt);
		pause_until_drained();

		// Fill the table to capacity
		while (held_count < CAPACITY)
			send_request(CMD_INSERT, IN_KEY_W'($urandom));
		pause_until_drained();

		// Work on a full table with the receiver stalling often
		stall_pct = 78;
		send_random(80, 60, 10);
		pause_until_drained();

		// Mixed traffic with a sparse sender
		stall_pct     = 0;
		send_idle_pct = 78;
		send_random(250, 45, 35);
		pause_until_drained();

		// Long receiver hold-off while the sender keeps offering
		send_idle_pct = 0;
		hold_req      = 1'b1;
		send_random(30, 45, 35);
		pause_until_drained();

		// Both sides idling
		send_idle_pct = 32;
		stall_pct     = 32;
		send_random(250, 45, 35);
		pause_until_drained();

		// Back to back
		send_idle_pct = 0;
		stall_pct     = 0;
		send_random(250, 40, 40);
		pause_until_drained();

		// Empty the table under receiver stalls
		stall_pct = 78;
		while (held_count != 0)
			send_request(CMD_DELETE, held_keys[$urandom_range(held_count - 1)]);
		pause_until_drained();

		// Traffic around an almost empty table
		stall_pct = 0;
		send_random(100, 30, 50);
		pause_until_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
